[hdl/tle_pkg.sv]
// Shared constants, codes and types of the terminal line editor.
package tle_pkg;

	// Longest line the store allows, terminator included
	localparam int unsigned MaxLine = 256;

	// Line limit from the store size, held to what an 8-bit count can show
	localparam int unsigned LineLimInt = ((MaxLine - 1) > 255) ? 255 : (MaxLine - 1);
	localparam logic [8:0] LineLim = 9'(LineLimInt);

	// Received key codes
	localparam logic [7:0] KeyCr  = 8'h0D;
	localparam logic [7:0] KeyLf  = 8'h0A;
	localparam logic [7:0] KeyDel = 8'h7F;
	localparam logic [7:0] KeyBs  = 8'h08;
	localparam logic [7:0] KeyInt = 8'h03;
	localparam logic [7:0] KeyEof = 8'h04;

	// Bytes sent to the terminal
	localparam logic [7:0] OutBell = 8'h07;
	localparam logic [7:0] OutSp   = 8'h20;
	localparam logic [7:0] OutBs   = 8'h08;
	localparam logic [7:0] OutLf   = 8'h0A;

	// Printable range
	localparam logic [7:0] PrintLo = 8'h20;
	localparam logic [7:0] PrintHi = 8'h7E;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t StStored    = 3'd0;
	localparam status_t StErased    = 3'd1;
	localparam status_t StEmpty     = 3'd2;
	localparam status_t StUnprint   = 3'd3;
	localparam status_t StFull      = 3'd4;
	localparam status_t StDone      = 3'd5;
	localparam status_t StCancelled = 3'd6;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CfgMaxLen = 2'd0;
	localparam cfg_idx_t CfgEcho   = 2'd1;
	localparam cfg_idx_t CfgCancel = 2'd2;

	// Configuration register reset values
	localparam logic [8:0] MaxLenRst = 9'd80;

	// Output beat position within an echoed erasure (BS, space, BS)
	typedef logic [1:0] beat_t;
	localparam beat_t BeatFirst = 2'd0;
	localparam beat_t BeatSpace = 2'd1;
	localparam beat_t BeatLast  = 2'd2;

	// Decoded result of one key, before output sequencing
	typedef struct packed {
		logic       term_valid;
		logic [7:0] term_byte;
		status_t    status;
		logic [7:0] stored_char;
		logic [7:0] char_index;
		logic [7:0] line_length;
		logic       erase_echo;
	} res_t;

endpackage

[hdl/tle_if.sv]
// Handshake channels of the terminal line editor: key input and result output.
interface tle_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

interface tle_res_if;
	logic       valid;
	logic       ready;
	logic       term_valid;
	logic [7:0] term_byte;
	logic [2:0] status;
	logic [7:0] stored_char;
	logic [7:0] char_index;
	logic [7:0] line_length;
	logic       last;

	modport source (
		output valid, output term_valid, output term_byte, output status,
		output stored_char, output char_index, output line_length, output last,
		input ready
	);
	modport sink (
		input valid, input term_valid, input term_byte, input status,
		input stored_char, input char_index, input line_length, input last,
		output ready
	);
endinterface

[hdl/tle_step.sv]
// Key decoder and character count register of the terminal line editor.
module tle_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    key_byte,
	input  logic [8:0]    max_len,
	input  logic          echo_en,
	input  logic          cancel_en,
	output tle_pkg::res_t res
);

	logic [7:0] count_q;
	logic [7:0] count_d;
	logic [8:0] cap;
	logic [7:0] count_dec;
	logic [7:0] count_inc;

	// Work out the line capacity from the configured size
	always_comb begin
		cap = (max_len == 9'd0) ? 9'd0 : (max_len - 9'd1);
		if (cap > tle_pkg::LineLim) begin
			cap = tle_pkg::LineLim;
		end
	end

	assign count_dec = count_q - 8'd1;
	assign count_inc = count_q + 8'd1;

	// Decode one key against the current count
	always_comb begin
		res             = '0;
		res.line_length = count_q;
		count_d         = count_q;
		if (key_byte == tle_pkg::KeyCr || key_byte == tle_pkg::KeyLf) begin
			res.term_valid = 1'b1;
			res.term_byte  = tle_pkg::OutLf;
			res.status     = tle_pkg::StDone;
			count_d        = 8'd0;
		end else if ((key_byte == tle_pkg::KeyInt || key_byte == tle_pkg::KeyEof)
				&& cancel_en) begin
			res.status      = tle_pkg::StCancelled;
			res.line_length = 8'd0;
			count_d         = 8'd0;
		end else if (key_byte == tle_pkg::KeyDel || key_byte == tle_pkg::KeyBs) begin
			if (count_q == 8'd0) begin
				// Empty line: ring the bell whatever the echo setting
				res.term_valid  = 1'b1;
				res.term_byte   = tle_pkg::OutBell;
				res.status      = tle_pkg::StEmpty;
				res.line_length = 8'd0;
			end else begin
				res.term_valid  = echo_en;
				res.term_byte   = echo_en ? tle_pkg::OutBs : 8'd0;
				res.status      = tle_pkg::StErased;
				res.char_index  = count_dec;
				res.line_length = count_dec;
				res.erase_echo  = echo_en;
				count_d         = count_dec;
			end
		end else if (key_byte < tle_pkg::PrintLo || key_byte > tle_pkg::PrintHi) begin
			res.term_valid = echo_en;
			res.term_byte  = echo_en ? tle_pkg::OutBell : 8'd0;
			res.status     = tle_pkg::StUnprint;
		end else if ({1'b0, count_q} >= cap) begin
			res.term_valid = echo_en;
			res.term_byte  = echo_en ? tle_pkg::OutBell : 8'd0;
			res.status     = tle_pkg::StFull;
		end else begin
			res.term_valid  = echo_en;
			res.term_byte   = echo_en ? key_byte : 8'd0;
			res.status      = tle_pkg::StStored;
			res.stored_char = key_byte;
			res.char_index  = count_q;
			res.line_length = count_inc;
			count_d         = count_inc;
		end
	end

	// Update the count on every accepted key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

endmodule

[hdl/tle_emit.sv]
// Result register and output beat sequencer of the terminal line editor.
module tle_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tle_pkg::res_t res_d,
	output logic          take,
	tle_res_if.source     res
);

	logic          valid_q;
	tle_pkg::res_t desc_q;
	tle_pkg::beat_t beat_q;
	logic          is_last;
	logic          fire;

	assign is_last = !desc_q.erase_echo || (beat_q == tle_pkg::BeatLast);
	assign fire    = valid_q && res.ready;
	// Free for a new item when empty or when the final beat leaves now
	assign take    = !valid_q || (res.ready && is_last);

	// Drive the result beat, with a space in the middle of an echoed erasure
	always_comb begin
		res.valid       = valid_q;
		res.term_valid  = desc_q.term_valid;
		res.term_byte   = (desc_q.erase_echo && beat_q == tle_pkg::BeatSpace)
			? tle_pkg::OutSp : desc_q.term_byte;
		res.status      = desc_q.status;
		res.stored_char = desc_q.stored_char;
		res.char_index  = desc_q.char_index;
		res.line_length = desc_q.line_length;
		res.last        = is_last;
	end

	// Hold control: occupancy and beat position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= tle_pkg::BeatFirst;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= tle_pkg::BeatFirst;
		end else if (fire) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// Capture the decoded result
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= res_d;
		end
	end

endmodule

[hdl/terminal_line_editor_core.sv]
// Top level of the terminal line editor: configuration registers, decoder and output sequencer.
// A key is decoded in the cycle it is taken and its result beat is on the result channel
// from the next cycle. The result register holds one key's result.
// The next key is taken in the same cycle that the final beat of the previous result is
// taken, or in any cycle when the register is empty. Single-result keys therefore run at
// one key per cycle while the result side takes every beat. A result stalled on the output
// holds the key input, and key ready follows result ready in the same cycle. An echoed
// erasure gives three result beats (BS, space, BS) and holds the key input until its final
// beat is taken. The sequencer in tle_emit sets this rate.
module terminal_line_editor_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	tle_key_if.sink    key,
	tle_res_if.source  res
);

	logic [8:0]    max_len_q;
	logic          echo_en_q;
	logic          cancel_en_q;
	logic          take;
	logic          accept;
	tle_pkg::res_t step_res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= tle_pkg::MaxLenRst;
			echo_en_q   <= 1'b1;
			cancel_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tle_pkg::CfgMaxLen: max_len_q   <= cfg_data;
				tle_pkg::CfgEcho:   echo_en_q   <= cfg_data[0];
				tle_pkg::CfgCancel: cancel_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign key.ready = take;
	assign accept    = key.valid && take;

	tle_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.key_byte  (key.key_byte),
		.max_len   (max_len_q),
		.echo_en   (echo_en_q),
		.cancel_en (cancel_en_q),
		.res       (step_res)
	);

	tle_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.res_d  (step_res),
		.take   (take),
		.res    (res)
	);

endmodule

[bench/line_edit_checker.sv]
`timescale 1ns / 1ps
// Watches the key and result channels of the line editor, predicts every result beat and compares.
module line_edit_checker
	import tle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	tle_key_if          key,
	tle_res_if          res,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned beats_seen
);

	// One result beat as it appears on the result channel
	typedef struct packed {
		logic       term_valid;
		logic [7:0] term_byte;
		status_t    status;
		logic [7:0] stored_char;
		logic [7:0] char_index;
		logic [7:0] line_length;
		logic       last;
	} edit_beat_t;

	edit_beat_t  line_q[$];
	logic [7:0]  line_cnt;
	logic [8:0]  max_len;
	logic        echo_on;
	logic        cancel_on;
	edit_beat_t  want;
	edit_beat_t  got;

	function automatic edit_beat_t mk_beat(input logic tv, input logic [7:0] tb,
			input status_t st, input logic [7:0] sc, input logic [7:0] ci,
			input logic [7:0] ll, input logic lst);
		edit_beat_t b;
		b = '{term_valid: tv, term_byte: tb, status: st, stored_char: sc,
			char_index: ci, line_length: ll, last: lst};
		return b;
	endfunction

	// Edit the line with one key and queue the beats it must give
	task automatic decode_key(input logic [7:0] ch);
		logic [8:0] room;
		logic [7:0] n;
		n = line_cnt;
		room = (max_len == 9'd0) ? 9'd0 : max_len - 9'd1;
		if (room > LineLim) begin
			room = LineLim;
		end
		if (ch == KeyCr || ch == KeyLf) begin
			line_q.push_back(mk_beat(1'b1, OutLf, StDone, 8'd0, 8'd0, n, 1'b1));
			line_cnt = 8'd0;
		end else if ((ch == KeyInt || ch == KeyEof) && cancel_on) begin
			line_q.push_back(mk_beat(1'b0, 8'd0, StCancelled, 8'd0, 8'd0, 8'd0, 1'b1));
			line_cnt = 8'd0;
		end else if (ch == KeyDel || ch == KeyBs) begin
			if (n == 8'd0) begin
				// bell on an empty line, whatever the echo setting
				line_q.push_back(mk_beat(1'b1, OutBell, StEmpty, 8'd0, 8'd0, 8'd0, 1'b1));
			end else begin
				n = n - 8'd1;
				line_cnt = n;
				if (!echo_on) begin
					line_q.push_back(mk_beat(1'b0, 8'd0, StErased, 8'd0, n, n, 1'b1));
				end else begin
					line_q.push_back(mk_beat(1'b1, OutBs, StErased, 8'd0, n, n, 1'b0));
					line_q.push_back(mk_beat(1'b1, OutSp, StErased, 8'd0, n, n, 1'b0));
					line_q.push_back(mk_beat(1'b1, OutBs, StErased, 8'd0, n, n, 1'b1));
				end
			end
		end else if (ch < PrintLo || ch > PrintHi) begin
			line_q.push_back(mk_beat(echo_on, echo_on ? OutBell : 8'd0, StUnprint,
				8'd0, 8'd0, n, 1'b1));
		end else if ({1'b0, n} >= room) begin
			// count may sit above the room after max_len was lowered; keep it
			line_q.push_back(mk_beat(echo_on, echo_on ? OutBell : 8'd0, StFull,
				8'd0, 8'd0, n, 1'b1));
		end else begin
			line_q.push_back(mk_beat(echo_on, echo_on ? ch : 8'd0, StStored,
				ch, n, n + 8'd1, 1'b1));
			line_cnt = n + 8'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt = 8'd0;
			max_len = MaxLenRst;
			echo_on = 1'b1;
			cancel_on = 1'b1;
			line_q.delete();
			fail_count = 0;
			beats_seen = 0;
			pending = 0;
		end else begin
			// predict first, so a beat of this very key lands behind older ones
			if (key.valid && key.ready) begin
				decode_key(key.key_byte);
			end

			// retire one result beat against the oldest prediction
			if (res.valid && res.ready) begin
				got = {res.term_valid, res.term_byte, res.status, res.stored_char,
					res.char_index, res.line_length, res.last};
				beats_seen++;
				if (line_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t: result beat %0d arrived with nothing predicted: st=%0d byte=%h",
							$realtime, beats_seen, got.status, got.term_byte);
					end
				end else begin
					want = line_q.pop_front();
					if (got.term_valid !== want.term_valid || got.term_byte !== want.term_byte
							|| got.status !== want.status
							|| got.stored_char !== want.stored_char
							|| got.char_index !== want.char_index
							|| got.line_length !== want.line_length
							|| got.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%t: result beat %0d mismatch", $realtime, beats_seen);
							$display("  expected tv=%0b byte=%h st=%0d chr=%h idx=%0d len=%0d last=%0b",
								want.term_valid, want.term_byte, want.status, want.stored_char,
								want.char_index, want.line_length, want.last);
							$display("  actual   tv=%0b byte=%h st=%0d chr=%h idx=%0d len=%0d last=%0b",
								got.term_valid, got.term_byte, got.status, got.stored_char,
								got.char_index, got.line_length, got.last);
						end
					end
				end
			end

			// track register writes for the following keys
			if (cfg_we) begin
				case (cfg_index)
					CfgMaxLen: begin
						max_len = cfg_data;
					end
					CfgEcho: begin
						echo_on = cfg_data[0];
					end
					CfgCancel: begin
						cancel_on = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			pending = line_q.size();
		end
	end

endmodule

[bench/terminal_line_editor_core_test.sv]
`timescale 1ns / 1ps
// Bench top of the line editor: clock, reset, key and register stimulus, and the verdict.
module terminal_line_editor_core_test;
	import tle_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned PhaseKeys  = 14;
	localparam int unsigned FillKeys   = 10;

	// register settings of the random phases
	localparam logic [8:0] PhaseLen [8] = '{9'd2, 9'd256, 9'd5, 9'd1, 9'd80, 9'd3, 9'd256, 9'd8};
	localparam logic PhaseEcho [8]      = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
	localparam logic PhaseCancel [8]    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned beats_seen;
	int unsigned keys_sent = 0;
	int unsigned settings_run = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic [8:0]  cur_max_len = MaxLenRst;

	tle_key_if key ();
	tle_res_if res ();

	terminal_line_editor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key),
		.res       (res)
	);

	line_edit_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key        (key),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending),
		.beats_seen (beats_seen)
	);

	always #6 clk = ~clk;

	// stall the result channel at random
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// give up on a hung run
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("no progress within %0d cycles", CycleLimit);
		$display("Simulation FAILED");
		$finish;
	end

	// offer one key beat, with random gaps ahead of it, and hold it until taken
	task automatic send_key(input logic [7:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			key.valid <= 1'b0;
			@(negedge clk);
		end
		key.valid <= 1'b1;
		key.key_byte <= code;
		do @(posedge clk); while (!key.ready);
		@(negedge clk);
		keys_sent++;
	endtask

	// drop valid and wait until every predicted beat has come out
	task automatic drain();
		key.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic load_config(input logic [8:0] len, input logic echo, input logic cancel);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CfgMaxLen;
		cfg_data <= len;
		@(negedge clk);
		cfg_index <= CfgEcho;
		cfg_data <= {8'd0, echo};
		@(negedge clk);
		cfg_index <= CfgCancel;
		cfg_data <= {8'd0, cancel};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_max_len = len;
		settings_run++;
	endtask

	// a typed line with some erasures, ended or cancelled, or else a burst of noise
	task automatic random_line();
		int unsigned len;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 78) begin
			len = $urandom_range((cur_max_len > 9'd10) ? 12 : int'(cur_max_len) + 1, 0);
			repeat (len) begin
				if ($urandom_range(99) < 15) begin
					send_key($urandom_range(1) ? KeyBs : KeyDel);
				end else begin
					send_key(8'($urandom_range(PrintHi, PrintLo)));
				end
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_key(KeyCr);
			end else if (pick < 85) begin
				send_key(KeyLf);
			end else if (pick < 93) begin
				send_key(KeyInt);
			end else begin
				send_key(KeyEof);
			end
		end else begin
			repeat ($urandom_range(4, 1)) send_key(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int unsigned start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgMaxLen;
		cfg_data = 9'd0;
		key.valid = 1'b0;
		key.key_byte = 8'd0;
		res.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed keys at the reset settings: erasures, code extremes, end and cancel
		send_key(KeyBs);
		send_key(PrintLo);
		send_key(PrintHi);
		send_key(8'h41);
		send_key(KeyBs);
		send_key(KeyDel);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(KeyCr);
		send_key(KeyLf);
		send_key(8'h78);
		send_key(KeyInt);
		send_key(KeyEof);

		// silent line with cancel off: full refusal, quiet erase, Ctrl-C refused
		load_config(9'd3, 1'b0, 1'b0);
		send_key(8'h61);
		send_key(8'h62);
		send_key(8'h63);
		send_key(KeyBs);
		send_key(KeyInt);
		send_key(KeyLf);

		// zero length leaves no room at all
		load_config(9'd0, 1'b1, 1'b1);
		send_key(8'h7A);
		send_key(KeyCr);

		// lower max_len under a partly typed line
		load_config(MaxLenRst, 1'b1, 1'b1);
		send_key(8'h70);
		send_key(8'h71);
		send_key(8'h72);
		load_config(9'd2, 1'b1, 1'b1);
		send_key(8'h74);
		send_key(KeyCr);

		// random phases over several settings and idling patterns
		for (int p = 0; p < 8; p++) begin
			load_config(PhaseLen[p], PhaseEcho[p], PhaseCancel[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					send_idle_pct = 25;
					stall_pct = 25;
				end
			endcase
			// type a short line past its room
			if (p == 7) begin
				repeat (FillKeys) send_key(8'($urandom_range(PrintHi, PrintLo)));
				send_key(KeyCr);
			end
			start = keys_sent;
			while (keys_sent - start < PhaseKeys) begin
				random_line();
			end
		end

		drain();
		$display("%0d keys sent, %0d result beats checked under %0d register settings,",
			keys_sent, beats_seen, settings_run);
		$display("from empty to full lines, with gaps and stalls on both channels");
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[terminal_line_editor_core.f]
hdl/tle_pkg.sv
hdl/tle_if.sv
hdl/tle_step.sv
hdl/tle_emit.sv
hdl/terminal_line_editor_core.sv
bench/line_edit_checker.sv
bench/terminal_line_editor_core_test.sv
